// ----- rtl/qls_pkg.sv -----
package qls_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               dropped;
  } out_t;

endpackage

// ----- rtl/qls_ram.sv -----
module qls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/quicksort_lomuto_sorter_top.sv -----
// While loading, the block accepts a transfer in every cycle. A partition pops its range,
// reads the pivot, scans each element, swaps through the single read port of the element
// RAM, places the pivot and pushes the remaining subranges; setup pushes the whole range.
// Each result passes a RAM read and the output register and is held while out_ready is
// low; the next batch is taken after the final result.
// Reset (rst_n low, synchronous) clears the state, counts and flags but not the RAMs.
module quicksort_lomuto_sorter_top #(
  parameter int SIZE = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qls_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qls_pkg::out_t out_data
);

  import qls_pkg::*;

  localparam int IW = $clog2(SIZE);
  localparam int CW = IW + 1;
  localparam int SW = 2 * IW;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_POPW   = 4'd3;
  localparam logic [3:0] S_PIVW   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_SCANW  = 4'd6;
  localparam logic [3:0] S_SWPW   = 4'd7;
  localparam logic [3:0] S_SWPWR  = 4'd8;
  localparam logic [3:0] S_FINW   = 4'd9;
  localparam logic [3:0] S_FINWR  = 4'd10;
  localparam logic [3:0] S_PUSH1  = 4'd11;
  localparam logic [3:0] S_PUSH2  = 4'd12;
  localparam logic [3:0] S_EMRD   = 4'd13;
  localparam logic [3:0] S_EMW    = 4'd14;
  localparam logic [3:0] S_EMHOLD = 4'd15;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CW-1:0]      sp_r, sp_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic [IW-1:0]      j_r, j_nxt;
  logic [IW-1:0]      e_r, e_nxt;
  logic signed [31:0] pivot_r, pivot_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [31:0] b_r, b_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               st_we;
  logic [IW-1:0]      st_waddr;
  logic [31:0]        st_wdata;
  logic [IW-1:0]      st_raddr;
  logic [31:0]        st_rdata;
  logic               sk_we;
  logic [IW-1:0]      sk_waddr;
  logic [SW-1:0]      sk_wdata;
  logic [IW-1:0]      sk_raddr;
  logic [SW-1:0]      sk_rdata;

  logic [IW-1:0]      sk_lo, sk_hi;
  logic [CW-1:0]      cnt_m1, sp_m1;
  logic               is_final;

  assign sk_lo    = sk_rdata[SW-1:IW];
  assign sk_hi    = sk_rdata[IW-1:0];
  assign cnt_m1   = count_r - CW'(1);
  assign sp_m1    = sp_r - CW'(1);
  assign is_final = (({1'b0, e_r} + CW'(1)) == count_r);

  qls_ram #(.WIDTH(32), .DEPTH(SIZE)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qls_ram #(.WIDTH(SW), .DEPTH(SIZE)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    pivot_nxt     = pivot_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    st_we         = 1'b0;
    st_waddr      = k_r;
    st_wdata      = a_r;
    st_raddr      = j_r;
    sk_we         = 1'b0;
    sk_waddr      = sp_r[IW-1:0];
    sk_wdata      = {lo_r, hi_r};
    sk_raddr      = sp_m1[IW-1:0];

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < CW'(SIZE)) begin
            st_we     = 1'b1;
            st_waddr  = count_r[IW-1:0];
            st_wdata  = in_data.value;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        sp_nxt = '0;
        if (count_r >= CW'(2)) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {IW'(0), cnt_m1[IW-1:0]};
          sp_nxt   = CW'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          e_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          sp_nxt    = sp_m1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt = sk_lo;
        hi_nxt = sk_hi;
        if ((sk_lo >= sk_hi) || ({1'b0, sk_hi} >= count_r)) begin
          state_nxt = S_POP;
        end else begin
          st_raddr  = sk_hi;
          k_nxt     = sk_lo;
          j_nxt     = sk_lo;
          state_nxt = S_PIVW;
        end
      end
      S_PIVW: begin
        pivot_nxt = $signed(st_rdata);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (j_r < hi_r) begin
          st_raddr  = j_r;
          state_nxt = S_SCANW;
        end else if (k_r == hi_r) begin
          state_nxt = S_PUSH1;
        end else begin
          st_raddr  = k_r;
          state_nxt = S_FINW;
        end
      end
      S_SCANW: begin
        if ($signed(st_rdata) <= pivot_r) begin
          if (k_r == j_r) begin
            k_nxt     = k_r + IW'(1);
            j_nxt     = j_r + IW'(1);
            state_nxt = S_SCAN;
          end else begin
            a_nxt     = $signed(st_rdata);
            st_raddr  = k_r;
            state_nxt = S_SWPW;
          end
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SWPW: begin
        b_nxt     = $signed(st_rdata);
        st_we     = 1'b1;
        st_waddr  = k_r;
        st_wdata  = a_r;
        state_nxt = S_SWPWR;
      end
      S_SWPWR: begin
        st_we     = 1'b1;
        st_waddr  = j_r;
        st_wdata  = b_r;
        k_nxt     = k_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        state_nxt = S_SCAN;
      end
      S_FINW: begin
        // The pivot slot is never written during the scan, so pivot_r is still current.
        b_nxt     = $signed(st_rdata);
        st_we     = 1'b1;
        st_waddr  = k_r;
        st_wdata  = pivot_r;
        state_nxt = S_FINWR;
      end
      S_FINWR: begin
        st_we     = 1'b1;
        st_waddr  = hi_r;
        st_wdata  = b_r;
        state_nxt = S_PUSH1;
      end
      S_PUSH1: begin
        if (({1'b0, k_r} > ({1'b0, lo_r} + CW'(1))) && (sp_r < CW'(SIZE))) begin
          sk_we    = 1'b1;
          sk_wdata = {lo_r, k_r - IW'(1)};
          sp_nxt   = sp_r + CW'(1);
        end
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        if ((({1'b0, k_r} + CW'(1)) < {1'b0, hi_r}) && (sp_r < CW'(SIZE))) begin
          sk_we    = 1'b1;
          sk_wdata = {k_r + IW'(1), hi_r};
          sp_nxt   = sp_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_EMRD: begin
        st_raddr  = e_r;
        state_nxt = S_EMW;
      end
      S_EMW: begin
        out_data_nxt.sorted_value = $signed(st_rdata);
        out_data_nxt.final_res    = is_final;
        out_data_nxt.dropped      = ovf_r;
        out_valid_nxt             = 1'b1;
        state_nxt                 = S_EMHOLD;
      end
      S_EMHOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.final_res) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            sp_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + IW'(1);
            state_nxt = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    e_r        <= e_nxt;
    pivot_r    <= pivot_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/qls_checker.sv -----
module qls_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input qls_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input qls_pkg::out_t out_data
);

  import qls_pkg::*;

  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // The transfer that closes a batch returns the block to loading.
  a_final_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.final_res) |=> in_ready)
    else $error("block not ready after final result");

  // The last element starts the sort, which blocks further input.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last) |=> !in_ready)
    else $error("input still accepted after last element");

endmodule

bind quicksort_lomuto_sorter_top qls_checker u_qls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_quicksort_lomuto_sorter_top.sv -----
`timescale 1ns / 1ps

module tb_quicksort_lomuto_sorter_top;
  import qls_pkg::*;

  localparam int DEPTH = 64;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  localparam int TAIL_CYCLES = 40;

  typedef enum int {
    SHAPE_MIXED,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT
  } batch_shape_t;

  class sort_scoreboard;
    logic signed [31:0] held_vals[DEPTH];
    int held;
    bit overflow;
    out_t sorted_q[$];
    int errors;
    int batches;
    int overflow_batches;
    int checked;

    function new();
      held = 0;
      overflow = 1'b0;
      errors = 0;
      batches = 0;
      overflow_batches = 0;
      checked = 0;
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // In-place ascending quicksort, last element of each range as pivot,
    // with pending ranges kept on an explicit stack.
    function void sort_held();
      int stk_lo[DEPTH];
      int stk_hi[DEPTH];
      int sp;
      int lo;
      int hi;
      int k;
      int j;
      logic signed [31:0] pivot;
      logic signed [31:0] tmp;
      sp = 0;
      if (held >= 2) begin
        stk_lo[0] = 0;
        stk_hi[0] = held - 1;
        sp = 1;
      end
      while (sp > 0) begin
        sp--;
        lo = stk_lo[sp];
        hi = stk_hi[sp];
        if (lo >= hi) continue;
        pivot = held_vals[hi];
        k = lo;
        for (j = lo; j < hi; j++) begin
          if (held_vals[j] <= pivot) begin
            tmp = held_vals[k];
            held_vals[k] = held_vals[j];
            held_vals[j] = tmp;
            k++;
          end
        end
        tmp = held_vals[k];
        held_vals[k] = held_vals[hi];
        held_vals[hi] = tmp;
        if (k > lo + 1 && sp < DEPTH) begin
          stk_lo[sp] = lo;
          stk_hi[sp] = k - 1;
          sp++;
        end
        if (k + 1 < hi && sp < DEPTH) begin
          stk_lo[sp] = k + 1;
          stk_hi[sp] = hi;
          sp++;
        end
      end
    endfunction

    function void note_input(input in_t d);
      out_t r;
      int k;
      if (held < DEPTH) begin
        held_vals[held] = d.value;
        held++;
      end else begin
        overflow = 1'b1;
      end
      if (d.last) begin
        sort_held();
        for (k = 0; k < held; k++) begin
          r.sorted_value = held_vals[k];
          r.final_res = (k == held - 1);
          r.dropped = overflow;
          sorted_q.push_back(r);
        end
        batches++;
        if (overflow) overflow_batches++;
        held = 0;
        overflow = 1'b0;
      end
    endfunction

    task check_result(input out_t got);
      out_t want;
      if (sorted_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", got.sorted_value));
        return;
      end
      want = sorted_q.pop_front();
      checked++;
      if (got.sorted_value !== want.sorted_value)
        report($sformatf("sorted_value got %0d want %0d", got.sorted_value,
                         want.sorted_value));
      if (got.final_res !== want.final_res)
        report($sformatf("final_res got %b want %b", got.final_res, want.final_res));
      if (got.dropped !== want.dropped)
        report($sformatf("dropped got %b want %b", got.dropped, want.dropped));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  sort_scoreboard sb;

  quicksort_lomuto_sorter_top #(
    .SIZE(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom;
    if (r < 85) return int'($urandom_range(8)) - 4;
    case ($urandom_range(3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_value(input logic signed [31:0] v, input logic is_last);
    in_t item;
    item.value = v;
    item.last = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic send_batch(input int n, input batch_shape_t shape);
    logic signed [31:0] base;
    logic signed [31:0] v;
    int i;
    base = int'($urandom_range(2000)) - 1000;
    for (i = 0; i < n; i++) begin
      case (shape)
        SHAPE_RISING: v = base + i;
        SHAPE_FALLING: v = base - i;
        SHAPE_FLAT: v = base;
        default: v = pick_value();
      endcase
      send_value(v, i == n - 1);
    end
  endtask

  // Hold the input low until every outstanding sorted value has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int target, input int big_size,
                              input batch_shape_t big_shape);
    int start;
    int n;
    batch_shape_t shape;
    start = items_sent;
    send_batch(big_size, big_shape);
    while (items_sent - start < target) begin
      n = $urandom_range(10, 1);
      case ($urandom_range(9))
        0: shape = SHAPE_RISING;
        1: shape = SHAPE_FALLING;
        2: shape = SHAPE_FLAT;
        default: shape = SHAPE_MIXED;
      endcase
      send_batch(n, shape);
    end
  endtask

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_stall_pct = 81;

    // Single-element batches, then pairs at both extremes, then a five-element batch.
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b1);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b1);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
    // Ties: all equal, then repeated pairs.
    send_batch(4, SHAPE_FLAT);
    send_value(-32'sd3, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd0, 1'b1);
    wait_drained();

    // One item past capacity: the dropped item itself carries the last flag.
    random_phase(80, DEPTH + 1, SHAPE_MIXED);
    wait_drained();

    send_idle_pct = 81;
    recv_stall_pct = 19;
    // Exactly full store with already ordered input.
    random_phase(80, DEPTH, SHAPE_RISING);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(80, DEPTH + 6, SHAPE_FALLING);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d batches (%0d with dropped items); checked %0d results.",
             items_sent, sb.batches, sb.overflow_batches, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
